[rtl/core/rbp_pkg.sv]
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared types and constants of the reference-counted buffer pool.
// ----------------------------------------------------------------------------
package rbp_pkg;

  // Pool defaults
  localparam int SLOTS_DEFAULT      = 8;
  localparam int COUNT_BITS_DEFAULT = 8;

  // Field widths on the ports
  localparam int OP_W        = 2;
  localparam int INDEX_W     = 3;
  localparam int ACTIVE_W    = 4;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 8;
  localparam int FREE_W      = 4;

  // Active slot count after reset
  localparam int ACTIVE_RESET = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_GET   = 2'd0;
  localparam logic [OP_W-1:0] OP_REF   = 2'd1;
  localparam logic [OP_W-1:0] OP_UNREF = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SATURATED  = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the input transaction, start the count read
    logic exec;   // commit the op and load the result register
  } rbp_cmd_t;

endpackage

[rtl/core/refcounted_buffer_pool_core.sv]
// ----------------------------------------------------------------------------
// refcounted_buffer_pool_core
// Reference-counted buffer pool: get / ref / unref on a pool of slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one op transaction: op and
//   slot_index. Output channel (out_valid / out_stall) returns exactly one
//   result transaction per op: status, granted_slot, slot_released,
//   count_after and free_slots.
//   cfg_write with active_slots sets the number of slots in use and
//   re-initializes the pool (all slots freed). Write only while idle.
// Operation:
//   A taken transaction first reads its slot count from the count memory
//   into a register; the op is then decoded and committed and its result
//   registered. No new transaction is taken while an op is in execution.
// Reset:
//   Synchronous rst frees all slots, sets the active count to 8 and empties
//   the output register. The count memory itself is not cleared; the busy
//   marks gate its reads, so no clearing pass is needed.
// Backpressure:
//   While out_stall holds a result, the output holds steady and in_stall
//   stays high, so no new transaction enters.
// ----------------------------------------------------------------------------
module refcounted_buffer_pool_core #(
  parameter int SLOTS      = rbp_pkg::SLOTS_DEFAULT,
  parameter int COUNT_BITS = rbp_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_write,
  input  logic [rbp_pkg::ACTIVE_W-1:0]    active_slots,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rbp_pkg::OP_W-1:0]        op,
  input  logic [rbp_pkg::INDEX_W-1:0]     slot_index,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rbp_pkg::STATUS_W-1:0]    status,
  output logic [rbp_pkg::INDEX_W-1:0]     granted_slot,
  output logic                            slot_released,
  output logic [rbp_pkg::COUNT_OUT_W-1:0] count_after,
  output logic [rbp_pkg::FREE_W-1:0]      free_slots
);

  rbp_pkg::rbp_cmd_t cmd;

  // sequencer: handshakes and step commands
  rbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // pool state, count memory and result register
  rbp_datapath #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .active_slots  (active_slots),
    .cmd           (cmd),
    .op            (op),
    .slot_index    (slot_index),
    .status        (status),
    .granted_slot  (granted_slot),
    .slot_released (slot_released),
    .count_after   (count_after),
    .free_slots    (free_slots)
  );

endmodule

[rtl/core/rbp_ctrl.sv]
// ----------------------------------------------------------------------------
// rbp_ctrl
// Two-state sequencer: takes a transaction, then executes it and posts
// the result to the output register.
// ----------------------------------------------------------------------------
module rbp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output rbp_pkg::rbp_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  // hold off new work while busy or while a result is stuck downstream
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign cmd.load = in_valid && !in_stall;
  assign cmd.exec = (state == S_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/rbp_datapath.sv]
// ----------------------------------------------------------------------------
// rbp_datapath
// Busy marks, free counter, count memory, op decode and result register.
// ----------------------------------------------------------------------------
module rbp_datapath #(
  parameter int SLOTS      = rbp_pkg::SLOTS_DEFAULT,
  parameter int COUNT_BITS = rbp_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [rbp_pkg::ACTIVE_W-1:0]       active_slots,
  input  rbp_pkg::rbp_cmd_t                  cmd,
  input  logic [rbp_pkg::OP_W-1:0]           op,
  input  logic [rbp_pkg::INDEX_W-1:0]        slot_index,
  output logic [rbp_pkg::STATUS_W-1:0]       status,
  output logic [rbp_pkg::INDEX_W-1:0]        granted_slot,
  output logic                               slot_released,
  output logic [rbp_pkg::COUNT_OUT_W-1:0]    count_after,
  output logic [rbp_pkg::FREE_W-1:0]         free_slots
);

  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_SPAN = 1 << SLOT_W;
  localparam int ACT_W     = $clog2(SLOTS + 1);
  localparam int CW        = (ACT_W > rbp_pkg::ACTIVE_W) ? ACT_W : rbp_pkg::ACTIVE_W;
  localparam int RESET_EFF = (rbp_pkg::ACTIVE_RESET > SLOTS) ? SLOTS : rbp_pkg::ACTIVE_RESET;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  function automatic logic [CW-1:0] eff_of(input logic [rbp_pkg::ACTIVE_W-1:0] a);
    logic [CW-1:0] a_ext;
    a_ext = CW'(a);
    if (a == '0) begin
      eff_of = CW'(1);
    end else if (a_ext > CW'(SLOTS)) begin
      eff_of = CW'(SLOTS);
    end else begin
      eff_of = a_ext;
    end
  endfunction

  logic [rbp_pkg::ACTIVE_W-1:0] active_reg;
  logic [SLOTS-1:0]             busy;
  logic [CW-1:0]                free_total;
  logic [rbp_pkg::OP_W-1:0]     op_q;
  logic [rbp_pkg::INDEX_W-1:0]  idx_q;
  logic [COUNT_BITS-1:0]        mem [SLOTS];
  logic [COUNT_BITS-1:0]        rdata;

  logic [CW-1:0]          eff;
  logic [SLOTS-1:0]       act_mask;
  logic [SLOTS-1:0]       free_mask;
  logic                   grant_found;
  logic [SLOT_W-1:0]      grant_idx;
  logic [SLOT_SPAN-1:0]   busy_pad;
  logic [SLOT_W-1:0]      idx_a;
  logic [SLOT_W-1:0]      rd_addr;
  logic                   idx_bad;
  logic                   busy_sel;
  logic [COUNT_BITS-1:0]  cnt_cur;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic [COUNT_BITS-1:0]  cnt_dec;

  logic [rbp_pkg::STATUS_W-1:0] st;
  logic [SLOT_W-1:0]            gr;
  logic                         rel;
  logic [COUNT_BITS-1:0]        cnt_res;
  logic                         wr_en;
  logic [SLOT_W-1:0]            wr_addr;
  logic [COUNT_BITS-1:0]        wr_data;
  logic                         busy_set;
  logic                         busy_clr;
  logic                         ft_dec;
  logic                         ft_inc;
  logic [CW-1:0]                free_total_next;
  logic [SLOTS-1:0]             busy_next;

  assign eff      = eff_of(active_reg);
  assign idx_a    = SLOT_W'(idx_q);
  assign rd_addr  = SLOT_W'(slot_index);
  assign idx_bad  = CW'(idx_q) >= eff;
  assign busy_pad = SLOT_SPAN'(busy);
  assign busy_sel = busy_pad[idx_a];
  // a free slot always reads as count zero
  assign cnt_cur  = busy_sel ? rdata : '0;
  assign cnt_inc  = cnt_cur + 1'b1;
  assign cnt_dec  = (cnt_cur != '0) ? cnt_cur - 1'b1 : '0;

  // lowest free active slot
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      act_mask[i] = CW'(i) < eff;
    end
    free_mask   = ~busy & act_mask;
    grant_found = |free_mask;
    grant_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        grant_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    st       = rbp_pkg::ST_OK;
    gr       = '0;
    rel      = 1'b0;
    cnt_res  = '0;
    wr_en    = 1'b0;
    wr_addr  = idx_a;
    wr_data  = cnt_inc;
    busy_set = 1'b0;
    busy_clr = 1'b0;
    ft_dec   = 1'b0;
    ft_inc   = 1'b0;
    unique case (op_q)
      rbp_pkg::OP_GET: begin
        if (grant_found) begin
          wr_en    = 1'b1;
          wr_addr  = grant_idx;
          wr_data  = COUNT_BITS'(1);
          busy_set = 1'b1;
          ft_dec   = 1'b1;
          gr       = grant_idx;
          cnt_res  = COUNT_BITS'(1);
        end else begin
          st = rbp_pkg::ST_EXHAUSTED;
        end
      end
      rbp_pkg::OP_REF: begin
        if (idx_bad) begin
          st = rbp_pkg::ST_BAD_INDEX;
        end else if (!busy_sel) begin
          st      = rbp_pkg::ST_NOT_IN_USE;
          cnt_res = cnt_cur;
        end else if (cnt_cur == COUNT_MAX) begin
          st      = rbp_pkg::ST_SATURATED;
          cnt_res = cnt_cur;
        end else begin
          wr_en   = 1'b1;
          wr_data = cnt_inc;
          cnt_res = cnt_inc;
        end
      end
      rbp_pkg::OP_UNREF: begin
        if (idx_bad) begin
          st = rbp_pkg::ST_BAD_INDEX;
        end else if (!busy_sel) begin
          st      = rbp_pkg::ST_NOT_IN_USE;
          cnt_res = cnt_cur;
        end else begin
          wr_en   = 1'b1;
          wr_data = cnt_dec;
          cnt_res = cnt_dec;
          if (cnt_dec == '0) begin
            busy_clr = 1'b1;
            ft_inc   = 1'b1;
            rel      = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    free_total_next = free_total;
    if (ft_dec && (free_total != '0)) begin
      free_total_next = free_total - 1'b1;
    end else if (ft_inc && (free_total < eff)) begin
      free_total_next = free_total + 1'b1;
    end
    busy_next = busy;
    if (busy_set) begin
      busy_next[grant_idx] = 1'b1;
    end
    if (busy_clr) begin
      busy_next[idx_a] = 1'b0;
    end
  end

  // pool state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_reg <= rbp_pkg::ACTIVE_W'(rbp_pkg::ACTIVE_RESET);
      busy       <= '0;
      free_total <= CW'(RESET_EFF);
    end else if (cfg_write) begin
      active_reg <= active_slots;
      busy       <= '0;
      free_total <= eff_of(active_slots);
    end else if (cmd.exec) begin
      busy       <= busy_next;
      free_total <= free_total_next;
    end
  end

  // count memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.load) begin
      rdata <= mem[rd_addr];
    end
  end

  // captured transaction and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op;
      idx_q <= slot_index;
    end
    if (cmd.exec) begin
      status        <= st;
      granted_slot  <= rbp_pkg::INDEX_W'(gr);
      slot_released <= rel;
      count_after   <= rbp_pkg::COUNT_OUT_W'(cnt_res);
      free_slots    <= rbp_pkg::FREE_W'(free_total_next);
    end
  end

endmodule

[rtl/core/rbp_checker.sv]
// ----------------------------------------------------------------------------
// rbp_checker
// Port-level checks of the buffer pool, bound to the top level.
// ----------------------------------------------------------------------------
module rbp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rbp_pkg::STATUS_W-1:0]    status,
  input logic [rbp_pkg::INDEX_W-1:0]     granted_slot,
  input logic                            slot_released,
  input logic [rbp_pkg::COUNT_OUT_W-1:0] count_after,
  input logic [rbp_pkg::FREE_W-1:0]      free_slots
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(count_after)
      && $stable(free_slots))
    else $error("stalled result changed");

  // one op at a time: no transaction right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction taken while another is in flight");

  // exhausted pool reports no free slot and no grant
  a_exhausted: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == rbp_pkg::ST_EXHAUSTED) |->
      (free_slots == '0) && (granted_slot == '0) && (count_after == '0))
    else $error("exhausted result inconsistent");

  // a release only on a successful unref that reached zero
  a_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && slot_released |-> (status == rbp_pkg::ST_OK) && (count_after == '0))
    else $error("release with nonzero count or error status");

endmodule

bind refcounted_buffer_pool_core rbp_checker u_rbp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .granted_slot  (granted_slot),
  .slot_released (slot_released),
  .count_after   (count_after),
  .free_slots    (free_slots)
);

[sim/refcounted_buffer_pool_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// refcounted_buffer_pool_core_tb
// Self-checking bench for the buffer pool: a queue-fed driver offers get,
// ref and unref transactions in random bursts. A shadow pool predicts every
// reply, and a monitor compares each reply field by field in order.
// ----------------------------------------------------------------------------
module refcounted_buffer_pool_core_tb;

  localparam int SLOTS       = rbp_pkg::SLOTS_DEFAULT;
  localparam int COUNT_W     = rbp_pkg::COUNT_BITS_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 700;

  // Op code 3 has no name in the package; the pool treats it as a no-op
  localparam logic [rbp_pkg::OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [rbp_pkg::OP_W-1:0]    code;
    logic [rbp_pkg::INDEX_W-1:0] slot;
  } pool_op_t;

  typedef struct packed {
    logic [rbp_pkg::STATUS_W-1:0]    status;
    logic [rbp_pkg::INDEX_W-1:0]     granted;
    logic                            released;
    logic [rbp_pkg::COUNT_OUT_W-1:0] count;
    logic [rbp_pkg::FREE_W-1:0]      free;
  } pool_reply_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  // Block ports; every input starts at a known value
  logic                            cfg_write    = 1'b0;
  logic [rbp_pkg::ACTIVE_W-1:0]    active_slots = rbp_pkg::ACTIVE_W'(rbp_pkg::ACTIVE_RESET);
  logic                            in_valid     = 1'b0;
  logic                            in_stall;
  logic [rbp_pkg::OP_W-1:0]        op           = rbp_pkg::OP_GET;
  logic [rbp_pkg::INDEX_W-1:0]     slot_index   = '0;
  logic                            out_valid;
  logic                            out_stall    = 1'b0;
  logic [rbp_pkg::STATUS_W-1:0]    status;
  logic [rbp_pkg::INDEX_W-1:0]     granted_slot;
  logic                            slot_released;
  logic [rbp_pkg::COUNT_OUT_W-1:0] count_after;
  logic [rbp_pkg::FREE_W-1:0]      free_slots;

  refcounted_buffer_pool_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .active_slots (active_slots),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .slot_index   (slot_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_slot (granted_slot),
    .slot_released(slot_released),
    .count_after  (count_after),
    .free_slots   (free_slots)
  );

  // --------------------------------------------------------------------------
  // Shadow pool: busy marks, reference counts and the free total
  // --------------------------------------------------------------------------
  logic               shadow_busy [SLOTS];
  logic [COUNT_W-1:0] shadow_count[SLOTS];
  int                 shadow_free;
  int                 shadow_active;

  pool_op_t    op_queue[$];      // transactions still to be offered
  pool_reply_t replies_due[$];   // predicted replies, oldest first

  int error_count  = 0;
  int ops_accepted = 0;
  int cycle_count  = 0;

  // Clamp a register value to the slot count the pool really uses
  function automatic int usable_slots(input logic [rbp_pkg::ACTIVE_W-1:0] v);
    if (v == 0) return 1;
    if (v > SLOTS) return SLOTS;
    return int'(v);
  endfunction

  // A register write (or reset) frees every slot and clears every count
  task automatic load_active(input logic [rbp_pkg::ACTIVE_W-1:0] v);
    shadow_active = usable_slots(v);
    for (int i = 0; i < SLOTS; i++) begin
      shadow_busy[i]  = 1'b0;
      shadow_count[i] = '0;
    end
    shadow_free = shadow_active;
  endtask

  // Apply one op to the shadow pool and produce the reply it must cause
  task automatic pool_apply_op(input pool_op_t t, output pool_reply_t r);
    bit found;
    found = 1'b0;
    r = '0;
    r.status = rbp_pkg::ST_OK;
    case (t.code)
      rbp_pkg::OP_GET: begin
        // Grant the lowest free active slot
        for (int i = 0; i < shadow_active && !found; i++) begin
          if (!shadow_busy[i]) begin
            shadow_busy[i]  = 1'b1;
            shadow_count[i] = COUNT_W'(1);
            if (shadow_free > 0) shadow_free--;
            r.granted = rbp_pkg::INDEX_W'(i);
            r.count   = rbp_pkg::COUNT_OUT_W'(1);
            found     = 1'b1;
          end
        end
        if (!found) r.status = rbp_pkg::ST_EXHAUSTED;
      end
      rbp_pkg::OP_REF, rbp_pkg::OP_UNREF: begin
        if (t.slot >= shadow_active) begin
          r.status = rbp_pkg::ST_BAD_INDEX;
        end else if (!shadow_busy[t.slot]) begin
          // Ref of a free slot and double free both leave the pool alone
          r.status = rbp_pkg::ST_NOT_IN_USE;
          r.count  = rbp_pkg::COUNT_OUT_W'(shadow_count[t.slot]);
        end else if (t.code == rbp_pkg::OP_REF) begin
          if (shadow_count[t.slot] == COUNT_MAX) r.status = rbp_pkg::ST_SATURATED;
          else shadow_count[t.slot]++;
          r.count = rbp_pkg::COUNT_OUT_W'(shadow_count[t.slot]);
        end else begin
          if (shadow_count[t.slot] > 0) shadow_count[t.slot]--;
          if (shadow_count[t.slot] == 0) begin
            shadow_busy[t.slot] = 1'b0;
            if (shadow_free < shadow_active) shadow_free++;
            r.released = 1'b1;
          end
          r.count = rbp_pkg::COUNT_OUT_W'(shadow_count[t.slot]);
        end
      end
      default: ;
    endcase
    r.free = rbp_pkg::FREE_W'(shadow_free);
  endtask

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_error($sformatf("reply %0d field %s: got %0d, want %0d",
                             ops_accepted, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer queued transactions in bursts with random gaps
  // --------------------------------------------------------------------------
  int          burst_left = 0;
  int          gap_left   = 0;
  pool_op_t    taken_op;
  pool_reply_t taken_reply;

  always @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      ops_accepted <= 0;
      burst_left   = 0;
      gap_left     = 0;
      load_active(rbp_pkg::ACTIVE_W'(rbp_pkg::ACTIVE_RESET));
    end else begin
      // Track register writes in the shadow pool at the same edge
      if (cfg_write) load_active(active_slots);

      // Predict the reply of a transaction taken at this edge
      if (in_valid && !in_stall) begin
        taken_op = op_queue.pop_front();
        pool_apply_op(taken_op, taken_reply);
        replies_due.push_back(taken_reply);
        ops_accepted <= ops_accepted + 1;
      end

      // Change the offer only when nothing is held by a stall
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          in_valid   <= 1'b1;
          op         <= op_queue[0].code;
          slot_index <= op_queue[0].slot;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall in modes of random length (never, light, heavy), and
  // hold off once for a long stretch so the block backs up into its input
  // --------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && ops_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare every reply taken with the oldest prediction
  // --------------------------------------------------------------------------
  pool_reply_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        report_error("reply with no transaction outstanding");
      end else begin
        want = replies_due.pop_front();
        check_field("status",        int'(status),        int'(want.status));
        check_field("granted_slot",  int'(granted_slot),  int'(want.granted));
        check_field("slot_released", int'(slot_released), int'(want.released));
        check_field("count_after",   int'(count_after),   int'(want.count));
        check_field("free_slots",    int'(free_slots),    int'(want.free));
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_op(input logic [rbp_pkg::OP_W-1:0] code,
                         input logic [rbp_pkg::INDEX_W-1:0] slot);
    pool_op_t t;
    t.code = code;
    t.slot = slot;
    op_queue.push_back(t);
  endtask

  task automatic wait_idle();
    while (op_queue.size() != 0 || replies_due.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  // Drain, let the pipeline settle, then rewrite the register
  task automatic write_active(input logic [rbp_pkg::ACTIVE_W-1:0] v);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_write    <= 1'b1;
    active_slots <= v;
    @(posedge clk);
    cfg_write    <= 1'b0;
  endtask

  // Mostly well-formed traffic: indices mostly inside the active range,
  // a mix of gets, refs and unrefs weighted per phase, a few spare op codes
  task automatic queue_random(input int n, input logic [rbp_pkg::ACTIVE_W-1:0] v,
                              input int get_w, input int ref_w, input int unref_w);
    int act;
    int pick;
    logic [rbp_pkg::OP_W-1:0]    code;
    logic [rbp_pkg::INDEX_W-1:0] slot;
    act = usable_slots(v);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < get_w)                        code = rbp_pkg::OP_GET;
      else if (pick < get_w + ref_w)           code = rbp_pkg::OP_REF;
      else if (pick < get_w + ref_w + unref_w) code = rbp_pkg::OP_UNREF;
      else                                     code = OP_SPARE;
      if ($urandom_range(0, 99) < 85) slot = rbp_pkg::INDEX_W'($urandom_range(0, act - 1));
      else                            slot = rbp_pkg::INDEX_W'($urandom_range(0, SLOTS - 1));
      push_op(code, slot);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Full pool after reset: free-slot misuse, spare op, grant and release
    push_op(rbp_pkg::OP_UNREF, 3'd7);   // double free
    push_op(rbp_pkg::OP_REF,   3'd3);   // ref of a free slot
    push_op(OP_SPARE,          3'd7);
    push_op(rbp_pkg::OP_GET,   3'd5);
    push_op(rbp_pkg::OP_GET,   3'd0);
    push_op(rbp_pkg::OP_REF,   3'd1);
    push_op(rbp_pkg::OP_UNREF, 3'd1);
    push_op(rbp_pkg::OP_UNREF, 3'd1);   // count reaches zero, slot freed
    push_op(rbp_pkg::OP_UNREF, 3'd1);   // double free
    push_op(rbp_pkg::OP_GET,   3'd2);   // lowest free slot is granted again

    // Active count zero acts as one: exhaustion and bad indices
    write_active(4'd0);
    push_op(rbp_pkg::OP_GET,   3'd0);
    push_op(rbp_pkg::OP_GET,   3'd0);   // pool exhausted
    push_op(rbp_pkg::OP_REF,   3'd1);   // bad index
    push_op(rbp_pkg::OP_UNREF, 3'd7);   // bad index
    push_op(rbp_pkg::OP_UNREF, 3'd0);
    push_op(OP_SPARE,          3'd0);

    // Active count above the pool size acts as the pool size
    write_active(4'd15);
    repeat (SLOTS) push_op(rbp_pkg::OP_GET, 3'd0);
    push_op(rbp_pkg::OP_GET, 3'd0);     // pool exhausted

    // Single slot flooded with refs to drive the count into saturation
    write_active(4'd1);
    push_op(rbp_pkg::OP_GET, 3'd0);
    queue_random(380, 4'd1, 3, 90, 5);

    // Random phases across several pool sizes, extremes included
    write_active(4'd2);
    queue_random(190, 4'd2, 35, 30, 30);
    write_active(4'd3);
    queue_random(190, 4'd3, 40, 25, 30);
    write_active(4'd5);
    queue_random(190, 4'd5, 30, 30, 35);
    write_active(4'd8);
    queue_random(200, 4'd8, 40, 25, 30);
    write_active(4'd15);
    queue_random(175, 4'd15, 45, 20, 30);

    // Drain and let the last reply settle
    wait_idle();
    repeat (6) @(posedge clk);
    if (replies_due.size() != 0) report_error("predicted replies never arrived");

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
